// ===== rtl/core/gelu_tanh_fast_exp_defines.svh =====
// assertion macros for the gelu tanh block
// needs a clock named clk and a reset named rst in the using module
`ifndef GELU_TANH_FAST_EXP_DEFINES_SVH
`define GELU_TANH_FAST_EXP_DEFINES_SVH
`ifndef SYNTH
`define GTE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GTE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) !(cond)) else $error("assertion failed");
`else
`define GTE_ASSERT_IMPLY(label, ante, cons)
`define GTE_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== rtl/core/gte_pkg.sv =====
// shared types and q.24 constants for the gelu tanh pipeline
// no dependencies
package gte_pkg;
  localparam int Q = 24;
  localparam logic [23:0] K_SQRT2PI = 24'd13386282;
  localparam logic [19:0] K_CUBIC = 20'd750193;
  localparam logic [24:0] K_LOG2E = 25'd24204406;
  localparam logic [23:0] K_SLOPE = 24'd16648389;
  localparam logic [24:0] K_OFFSET = 25'd15889924;
  localparam int DIV_STEPS = 25;

  typedef logic [48:0] den_t;
  typedef logic [24:0] low_t;
  typedef logic [24:0] quo_t;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        last;
    logic [23:0] mag;
  } side_t;
endpackage

// ===== rtl/core/gte_front.sv =====
// polynomial, clamp and exponential fit stages, ends in divider operands
// depends on gte_pkg
module gte_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [23:0]    x_in,
  input  logic           last_in,
  output gte_pkg::side_t side_o,
  output gte_pkg::den_t  den_o,
  output gte_pkg::den_t  rem_o,
  output gte_pkg::low_t  low_o
);
  import gte_pkg::*;

  localparam int SH = Q - FRAC_BITS;
  localparam logic [23:0] A_LIM = 24'(8 << FRAC_BITS);
  localparam logic [27:0] U_MAX = 28'd1 << 27;
  localparam logic [23:0] HALF = 24'd1 << 23;

  side_t s1, s2, s3, s4, s5, s6, s7, s8;
  logic [27:0] a1, a2, a3;
  logic [30:0] sq2;
  logic [33:0] cube3;
  logic [28:0] inner4;
  logic [27:0] u5;
  logic [4:0]  n6, n7;
  logic [23:0] f6;
  logic [24:0] m7;
  den_t        den8, rem8;
  low_t        low8;

  logic [23:0] mag_c;
  logic [55:0] p_sq;
  logic [58:0] p_cu;
  logic [53:0] p_in;
  logic [52:0] p_u;
  logic [52:0] p_z;
  logic [48:0] p_m;
  logic [48:0] e_c;
  den_t        den_c;
  logic [49:0] num_c;

  always_comb begin
    mag_c = x_in[23] ? (~x_in + 24'd1) : x_in;
    p_sq  = 56'(a1) * 56'(a1) + 56'(HALF);
    p_cu  = 59'(sq2) * 59'(a2) + 59'(HALF);
    p_in  = 54'(K_CUBIC) * 54'(cube3) + 54'(HALF);
    p_u   = 53'(K_SQRT2PI) * 53'(inner4) + 53'(HALF);
    p_z   = 53'({u5, 1'b0}) * 53'(K_LOG2E) + 53'(HALF);
    p_m   = 49'(K_SLOPE) * 49'(f6) + 49'(HALF);
    e_c   = 49'(m7) << n7;
    den_c = e_c + (49'd1 << Q);
    num_c = (50'd1 << 49) + 50'(den_c >> 1);
  end

  always_ff @(posedge clk) begin
    // valid bits
    if (rst) begin
      s1.valid <= 1'b0; s2.valid <= 1'b0; s3.valid <= 1'b0; s4.valid <= 1'b0;
      s5.valid <= 1'b0; s6.valid <= 1'b0; s7.valid <= 1'b0; s8.valid <= 1'b0;
    end else begin
      s1.valid <= in_valid; s2.valid <= s1.valid; s3.valid <= s2.valid;
      s4.valid <= s3.valid; s5.valid <= s4.valid; s6.valid <= s5.valid;
      s7.valid <= s6.valid; s8.valid <= s7.valid;
    end
    s1.neg <= x_in[23];
    s1.last <= last_in;
    s1.mag <= mag_c;
    a1 <= (mag_c > A_LIM) ? U_MAX : 28'(40'(mag_c) << SH);
    {s2.neg, s2.last, s2.mag} <= {s1.neg, s1.last, s1.mag};
    {s3.neg, s3.last, s3.mag} <= {s2.neg, s2.last, s2.mag};
    {s4.neg, s4.last, s4.mag} <= {s3.neg, s3.last, s3.mag};
    {s5.neg, s5.last, s5.mag} <= {s4.neg, s4.last, s4.mag};
    {s6.neg, s6.last, s6.mag} <= {s5.neg, s5.last, s5.mag};
    {s7.neg, s7.last, s7.mag} <= {s6.neg, s6.last, s6.mag};
    {s8.neg, s8.last, s8.mag} <= {s7.neg, s7.last, s7.mag};
    sq2 <= p_sq[54:24];
    a2 <= a1;
    cube3 <= p_cu[57:24];
    a3 <= a2;
    inner4 <= 29'(a3) + p_in[52:24];
    u5 <= (p_u[52:24] > 29'(U_MAX)) ? U_MAX : p_u[51:24];
    n6 <= p_z[52:48];
    f6 <= p_z[47:24];
    m7 <= K_OFFSET + p_m[48:24];
    n7 <= n6;
    // numerator top bits start the long division, rest feed in one per step
    den8 <= den_c;
    rem8 <= 49'(num_c[49:25]);
    low8 <= num_c[24:0];
  end

  assign side_o = s8;
  assign den_o  = den8;
  assign rem_o  = rem8;
  assign low_o  = low8;
endmodule

// ===== rtl/core/gte_div_stage.sv =====
// one restoring step of the pipelined reciprocal divider
// depends on gte_pkg
module gte_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  gte_pkg::side_t side_i,
  input  gte_pkg::den_t  den_i,
  input  gte_pkg::den_t  rem_i,
  input  gte_pkg::low_t  low_i,
  input  gte_pkg::quo_t  quo_i,
  output gte_pkg::side_t side_o,
  output gte_pkg::den_t  den_o,
  output gte_pkg::den_t  rem_o,
  output gte_pkg::low_t  low_o,
  output gte_pkg::quo_t  quo_o
);
  import gte_pkg::*;

  logic [49:0] trial;
  logic [49:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_i, low_i[24]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o.valid <= 1'b0;
    end else begin
      side_o.valid <= side_i.valid;
    end
    {side_o.neg, side_o.last, side_o.mag} <= {side_i.neg, side_i.last, side_i.mag};
    den_o <= den_i;
    rem_o <= ge ? diff[48:0] : trial[48:0];
    low_o <= {low_i[23:0], 1'b0};
    quo_o <= {quo_i[23:0], ge};
  end
endmodule

// ===== rtl/core/gte_back.sv =====
// tanh to gate factor, final product, rounding and saturation
// depends on gte_pkg
module gte_back (
  input  logic           clk,
  input  logic           rst,
  input  gte_pkg::side_t side_i,
  input  gte_pkg::quo_t  quo_i,
  output logic           done,
  output logic [23:0]    y_out,
  output logic           last_out
);
  import gte_pkg::*;

  side_t       b1, b2;
  logic [25:0] factor1;
  logic [25:0] ymag2;
  logic [50:0] p_y;
  logic [23:0] y_c;

  always_comb begin
    p_y = 51'(b1.mag) * 51'(factor1) + (51'd1 << Q);
    if (b2.neg) begin
      y_c = (ymag2 > 26'(24'd1 << 23)) ? 24'h800000 : (~ymag2[23:0] + 24'd1);
    end else begin
      y_c = (ymag2 > 26'h7FFFFF) ? 24'h7FFFFF : ymag2[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.valid <= 1'b0;
      b2.valid <= 1'b0;
      done <= 1'b0;
    end else begin
      b1.valid <= side_i.valid;
      b2.valid <= b1.valid;
      done <= b2.valid;
    end
    {b1.neg, b1.last, b1.mag} <= {side_i.neg, side_i.last, side_i.mag};
    {b2.neg, b2.last, b2.mag} <= {b1.neg, b1.last, b1.mag};
    // 1 + t with t = +-(1 - quo) reduces to quo or 2 - quo
    factor1 <= side_i.neg ? 26'(quo_i) : ((26'd1 << 25) - 26'(quo_i));
    ymag2 <= p_y[50:25];
    y_out <= y_c;
    last_out <= b2.last;
  end
endmodule

// ===== rtl/core/gelu_tanh_fast_exp.sv =====
// gelu (tanh form) over signed fixed-point activations, one transaction per cycle
// the path from the start edge to the done strobe runs through 8 polynomial and
// exponent stages, 25 divider steps of one quotient bit each, 3 output stages
// busy is never raised; throughput is one item per clock
// synchronous reset clears the valid bits only, no pending results survive it
module gelu_tanh_fast_exp #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] x_in,
  input  logic        last_in,
  output logic        done,
  output logic [23:0] y_out,
  output logic        last_out
);
  import gte_pkg::*;
  `include "gelu_tanh_fast_exp_defines.svh"

  localparam int LATENCY = 36;

  side_t side_d [0:DIV_STEPS];
  den_t  den_d  [0:DIV_STEPS];
  den_t  rem_d  [0:DIV_STEPS];
  low_t  low_d  [0:DIV_STEPS];
  quo_t  quo_d  [0:DIV_STEPS];

  assign busy = 1'b0;
  assign quo_d[0] = '0;

  gte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .x_in(x_in), .last_in(last_in),
    .side_o(side_d[0]), .den_o(den_d[0]), .rem_o(rem_d[0]), .low_o(low_d[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    gte_div_stage u_stage (
      .clk(clk), .rst(rst),
      .side_i(side_d[i]), .den_i(den_d[i]), .rem_i(rem_d[i]),
      .low_i(low_d[i]), .quo_i(quo_d[i]),
      .side_o(side_d[i+1]), .den_o(den_d[i+1]), .rem_o(rem_d[i+1]),
      .low_o(low_d[i+1]), .quo_o(quo_d[i+1])
    );
  end

  gte_back u_back (
    .clk(clk), .rst(rst), .side_i(side_d[DIV_STEPS]), .quo_i(quo_d[DIV_STEPS]),
    .done(done), .y_out(y_out), .last_out(last_out)
  );

  `GTE_ASSERT_IMPLY(a_start_done, start && !busy, ##LATENCY done)
  `GTE_ASSERT_IMPLY(a_done_start, done, $past(start, LATENCY))
  `GTE_ASSERT_IMPLY(a_last_kept, done, last_out == $past(last_in, LATENCY))
  `GTE_ASSERT_IMPLY(a_reset_clears, $past(rst), !done)
endmodule
